// File: sv/phdc_pkg.sv
// ---------------------------------------------------------------------------
// Position hold drive controller package
// Beat types, op codes, register indexes and reset values.
// ---------------------------------------------------------------------------
package phdc_pkg;

   localparam int TICKS_PER_TURN_DEF = 1024;

   // degrees in Q16.16: 360 * 65536 = 45 * 2**19
   localparam int DEG_SHIFT = 19;
   localparam int DEG_ODD   = 45;

   localparam logic [2:0] OP_POSITION  = 3'd0;
   localparam logic [2:0] OP_DISTANCE  = 3'd1;
   localparam logic [2:0] OP_SET_MOVE  = 3'd2;
   localparam logic [2:0] OP_SET_TURN  = 3'd3;
   localparam logic [2:0] OP_SET_REACH = 3'd4;

   localparam logic [2:0] REG_GAIN_MOVE          = 3'd0;
   localparam logic [2:0] REG_GAIN_MOVE_HEADING  = 3'd1;
   localparam logic [2:0] REG_GAIN_TURN          = 3'd2;
   localparam logic [2:0] REG_GAIN_TURN_DISTANCE = 3'd3;
   localparam logic [2:0] REG_MOVE_DEADBAND      = 3'd4;
   localparam logic [2:0] REG_TURN_DEADBAND      = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;

   localparam logic [15:0] GAIN_MOVE_RST          = 16'd6144;
   localparam logic [15:0] GAIN_MOVE_HEADING_RST  = 16'd41;
   localparam logic [15:0] GAIN_TURN_RST          = 16'd6144;
   localparam logic [15:0] GAIN_TURN_DISTANCE_RST = 16'd82;
   localparam logic [30:0] MOVE_DEADBAND_RST      = 31'd3277;
   localparam logic [15:0] TURN_DEADBAND_RST      = 16'd13;

   localparam logic [14:0] Q15_MAX = 15'h7fff;

   typedef struct packed {
      logic [2:0]          op;
      logic signed [31:0]  distance_now;
      logic signed [23:0]  heading_now;
      logic signed [31:0]  amount;
      logic [14:0]         limit_forward;
      logic [14:0]         limit_turn;
      logic signed [15:0]  duty;
   } phdc_req_type;

   typedef struct packed {
      logic signed [15:0]  forward_drive;
      logic signed [15:0]  turn_drive;
      logic                done_res;
   } phdc_rsp_type;

endpackage

// File: sv/phdc_chan_if.sv
// ---------------------------------------------------------------------------
// Position hold drive controller channel
// Valid/ready channel carrying one payload beat per handshake.
// ---------------------------------------------------------------------------
interface phdc_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/position_hold_drive_controller.sv
// ---------------------------------------------------------------------------
// Position hold drive controller
// Proportional move/turn controller with cross-axis hold and distance drive.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one beat per control tick or command. Op 0 (position
//   tick) and op 1 (distance tick) each give one rsp_chan beat with the
//   forward and turn drives and the done flag. Ops 2 to 4 latch a move, turn
//   or distance target from the current encoders and give no beat; codes 5
//   to 7 are dropped.
//   A beat accepted at one edge shows on rsp_chan at the next. One beat is
//   taken every cycle while req_chan.ready is high; the whole tick is
//   computed in a single pass into the result register, with two multipliers
//   (distance and heading correction) and a constant reciprocal divide for
//   turn targets. req_chan.ready is low only while a result waits and
//   rsp_chan.ready is low; the waiting result holds until taken.
//   Synchronous reset drops any waiting result, clears all targets and
//   active flags, sets the distance direction forward and loads the default
//   gains and deadbands. csr_* writes land at the next edge; the user must
//   make them only while the block is idle, as the block does not enforce it.
// ---------------------------------------------------------------------------
module position_hold_drive_controller
   import phdc_pkg::*;
#(
   parameter int TICKS_PER_TURN = TICKS_PER_TURN_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   phdc_chan_if.sink              req_chan,
   phdc_chan_if.source            rsp_chan
);

   localparam int TW = $clog2(TICKS_PER_TURN + 1);
   localparam int QW = 33 + TW;
   localparam int SW = QW - DEG_SHIFT;
   localparam int NW = SW - 1;
   localparam int KW = NW + $clog2(DEG_ODD);
   localparam int RW = NW + 1;
   localparam int PW = NW + RW;
   localparam int FW = ((SW > 24) ? SW : 24) + 1;
   localparam logic [63:0] RECIP_FULL = (64'd1 << KW) / DEG_ODD;
   localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];

   logic [15:0] gain_move_ff, gain_move_in;
   logic [15:0] gain_move_heading_ff, gain_move_heading_in;
   logic [15:0] gain_turn_ff, gain_turn_in;
   logic [15:0] gain_turn_distance_ff, gain_turn_distance_in;
   logic [30:0] move_deadband_ff, move_deadband_in;
   logic [15:0] turn_deadband_ff, turn_deadband_in;

   logic signed [31:0] move_target_ff, move_target_in;
   logic signed [23:0] move_heading_ff, move_heading_in;
   logic               move_active_ff, move_active_in;
   logic signed [23:0] turn_target_ff, turn_target_in;
   logic signed [31:0] turn_start_distance_ff, turn_start_distance_in;
   logic               turn_active_ff, turn_active_in;
   logic signed [31:0] reach_target_ff, reach_target_in;
   logic signed [23:0] reach_heading_ff, reach_heading_in;
   logic               reach_forward_ff, reach_forward_in;
   logic               reach_active_ff, reach_active_in;

   logic         rsp_valid_ff, rsp_valid_in;
   phdc_rsp_type rsp_data_ff, rsp_data_in;

   phdc_req_type req_beat;
   logic         req_take;
   logic         req_tick;

   logic signed [32:0] derr;
   logic [15:0]        dgain;
   logic signed [49:0] dprod;
   logic signed [49:0] dadj;
   logic signed [36:0] dcorr;
   logic [32:0]        derr_abs;
   logic signed [36:0] fwd_lim;
   logic signed [15:0] fwd_clamp;

   logic signed [24:0] herr;
   logic [15:0]        hgain;
   logic signed [41:0] hprod;
   logic signed [44:0] hcorr;
   logic [24:0]        herr_abs;
   logic [14:0]        trn_lim_u;
   logic signed [44:0] trn_lim;
   logic signed [15:0] trn_clamp;

   logic [14:0]        duty_mag;
   logic signed [32:0] rerr;

   logic signed [32:0] sum_target;
   logic signed [31:0] sat_target;

   logic signed [QW-1:0] tq;
   logic signed [SW-1:0] ts;
   logic                 tlow;
   logic [NW-1:0]        tu;
   logic [PW-1:0]        tprod;
   logic [NW-1:0]        tq0;
   logic [NW-1:0]        tr0;
   logic                 tbump;
   logic [NW-1:0]        tquo;
   logic [NW-1:0]        trem;
   logic                 trem_nz;
   logic signed [SW-1:0] tfloor;
   logic signed [FW-1:0] tsum;
   logic signed [FW-1:0] ttrunc;
   logic signed [23:0]   turn_sat;

   assign req_beat       = req_chan.payload;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign req_tick       = (req_beat.op == OP_POSITION) || (req_beat.op == OP_DISTANCE);

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // distance correction
   assign derr  = move_active_ff ? 33'(move_target_ff) - 33'(req_beat.distance_now)
                                 : 33'(turn_start_distance_ff) - 33'(req_beat.distance_now);
   assign dgain = move_active_ff ? gain_move_ff : gain_turn_distance_ff;
   assign dprod = 50'(derr) * 50'($signed({1'b0, dgain}));
   assign dadj  = dprod + (dprod[49] ? 50'sd8191 : 50'sd0);
   assign dcorr = 37'(dadj >>> 13);
   assign derr_abs = derr[32] ? 33'(-derr) : 33'(derr);
   assign fwd_lim  = 37'($signed({1'b0, req_beat.limit_forward}));

   always_comb begin
      if (dcorr > fwd_lim) begin
         fwd_clamp = 16'(fwd_lim);
      end else if (dcorr < -fwd_lim) begin
         fwd_clamp = 16'(-fwd_lim);
      end else begin
         fwd_clamp = 16'(dcorr);
      end
   end

   // heading correction
   always_comb begin
      if (req_beat.op == OP_DISTANCE) begin
         herr  = 25'(reach_heading_ff) - 25'(req_beat.heading_now);
         hgain = gain_move_heading_ff;
      end else if (move_active_ff) begin
         herr  = 25'(move_heading_ff) - 25'(req_beat.heading_now);
         hgain = gain_move_heading_ff;
      end else begin
         herr  = 25'(turn_target_ff) - 25'(req_beat.heading_now);
         hgain = gain_turn_ff;
      end
   end

   assign hprod     = 42'(herr) * 42'($signed({1'b0, hgain}));
   assign hcorr     = $signed({hprod, 3'b000});
   assign herr_abs  = herr[24] ? 25'(-herr) : 25'(herr);
   assign trn_lim_u = (req_beat.op == OP_DISTANCE) ? Q15_MAX : req_beat.limit_turn;
   assign trn_lim   = 45'($signed({1'b0, trn_lim_u}));

   always_comb begin
      if (hcorr > trn_lim) begin
         trn_clamp = 16'(trn_lim);
      end else if (hcorr < -trn_lim) begin
         trn_clamp = 16'(-trn_lim);
      end else begin
         trn_clamp = 16'(hcorr);
      end
   end

   // distance tick
   always_comb begin
      if (req_beat.duty == 16'sh8000) begin
         duty_mag = Q15_MAX;
      end else if (req_beat.duty[15]) begin
         duty_mag = 15'(-req_beat.duty);
      end else begin
         duty_mag = req_beat.duty[14:0];
      end
   end

   assign rerr = 33'(reach_target_ff) - 33'(req_beat.distance_now);

   // saturated targets
   assign sum_target = 33'(req_beat.distance_now) + 33'(req_beat.amount);
   assign sat_target = (sum_target[32] != sum_target[31])
                     ? (sum_target[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                     : sum_target[31:0];

   // turn target: heading plus amount * ticks / (360 * 65536), toward zero
   assign tq      = QW'(req_beat.amount) * QW'(TICKS_PER_TURN);
   assign ts      = SW'(tq >>> DEG_SHIFT);
   assign tlow    = |tq[DEG_SHIFT-1:0];
   assign tu      = ts[SW-1] ? ~ts[NW-1:0] : ts[NW-1:0];
   assign tprod   = PW'(tu) * PW'(RECIP);
   assign tq0     = NW'(tprod >> KW);
   assign tr0     = tu - NW'(tq0 * NW'(DEG_ODD));
   assign tbump   = tr0 >= NW'(DEG_ODD);
   assign tquo    = tq0 + NW'(tbump);
   assign trem    = tbump ? tr0 - NW'(DEG_ODD) : tr0;
   assign trem_nz = ts[SW-1] ? (trem != NW'(DEG_ODD - 1)) : (trem != '0);
   assign tfloor  = ts[SW-1] ? $signed(~{1'b0, tquo}) : $signed({1'b0, tquo});
   assign tsum    = FW'(req_beat.heading_now) + FW'(tfloor);
   assign ttrunc  = tsum + FW'(tsum[FW-1] && (tlow || trem_nz));
   assign turn_sat = (ttrunc[FW-1:23] != {(FW-23){ttrunc[FW-1]}})
                   ? (ttrunc[FW-1] ? 24'sh80_0000 : 24'sh7f_ffff)
                   : ttrunc[23:0];

   // result beat
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (req_beat.op == OP_POSITION) begin
         if (move_active_ff) begin
            rsp_data_in.forward_drive = fwd_clamp;
            rsp_data_in.turn_drive    = trn_clamp;
            rsp_data_in.done_res      = derr_abs < {2'b00, move_deadband_ff};
         end else if (turn_active_ff) begin
            rsp_data_in.forward_drive = fwd_clamp;
            rsp_data_in.turn_drive    = trn_clamp;
            rsp_data_in.done_res      = {herr_abs, 8'h00} < {17'd0, turn_deadband_ff};
         end else begin
            rsp_data_in.forward_drive = '0;
            rsp_data_in.turn_drive    = '0;
            rsp_data_in.done_res      = 1'b1;
         end
      end else begin
         if (reach_active_ff) begin
            rsp_data_in.forward_drive = reach_forward_ff ? $signed({1'b0, duty_mag})
                                                         : -$signed({1'b0, duty_mag});
            rsp_data_in.turn_drive    = trn_clamp;
            rsp_data_in.done_res      = reach_forward_ff ? (rerr[32] || (rerr == '0))
                                                         : !rerr[32];
         end else begin
            rsp_data_in.forward_drive = '0;
            rsp_data_in.turn_drive    = '0;
            rsp_data_in.done_res      = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = req_tick || (rsp_valid_ff && !rsp_chan.ready);
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // command state
   always_comb begin
      move_target_in         = move_target_ff;
      move_heading_in        = move_heading_ff;
      move_active_in         = move_active_ff;
      turn_target_in         = turn_target_ff;
      turn_start_distance_in = turn_start_distance_ff;
      turn_active_in         = turn_active_ff;
      reach_target_in        = reach_target_ff;
      reach_heading_in       = reach_heading_ff;
      reach_forward_in       = reach_forward_ff;
      reach_active_in        = reach_active_ff;
      if (req_take) begin
         unique case (req_beat.op)
            OP_SET_MOVE: begin
               move_target_in  = sat_target;
               move_heading_in = req_beat.heading_now;
               move_active_in  = 1'b1;
               turn_active_in  = 1'b0;
            end
            OP_SET_TURN: begin
               turn_target_in         = turn_sat;
               turn_start_distance_in = req_beat.distance_now;
               turn_active_in         = 1'b1;
               move_active_in         = 1'b0;
            end
            OP_SET_REACH: begin
               reach_target_in  = sat_target;
               reach_heading_in = req_beat.heading_now;
               reach_forward_in = !req_beat.amount[31] && (req_beat.amount != '0);
               reach_active_in  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // configuration
   always_comb begin
      gain_move_in          = gain_move_ff;
      gain_move_heading_in  = gain_move_heading_ff;
      gain_turn_in          = gain_turn_ff;
      gain_turn_distance_in = gain_turn_distance_ff;
      move_deadband_in      = move_deadband_ff;
      turn_deadband_in      = turn_deadband_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_GAIN_MOVE:          gain_move_in          = csr_wr_data[15:0];
            REG_GAIN_MOVE_HEADING:  gain_move_heading_in  = csr_wr_data[15:0];
            REG_GAIN_TURN:          gain_turn_in          = csr_wr_data[15:0];
            REG_GAIN_TURN_DISTANCE: gain_turn_distance_in = csr_wr_data[15:0];
            REG_MOVE_DEADBAND:      move_deadband_in      = csr_wr_data[30:0];
            REG_TURN_DEADBAND:      turn_deadband_in      = csr_wr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_move_ff           <= GAIN_MOVE_RST;
         gain_move_heading_ff   <= GAIN_MOVE_HEADING_RST;
         gain_turn_ff           <= GAIN_TURN_RST;
         gain_turn_distance_ff  <= GAIN_TURN_DISTANCE_RST;
         move_deadband_ff       <= MOVE_DEADBAND_RST;
         turn_deadband_ff       <= TURN_DEADBAND_RST;
         move_target_ff         <= '0;
         move_heading_ff        <= '0;
         move_active_ff         <= 1'b0;
         turn_target_ff         <= '0;
         turn_start_distance_ff <= '0;
         turn_active_ff         <= 1'b0;
         reach_target_ff        <= '0;
         reach_heading_ff       <= '0;
         reach_forward_ff       <= 1'b1;
         reach_active_ff        <= 1'b0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         gain_move_ff           <= gain_move_in;
         gain_move_heading_ff   <= gain_move_heading_in;
         gain_turn_ff           <= gain_turn_in;
         gain_turn_distance_ff  <= gain_turn_distance_in;
         move_deadband_ff       <= move_deadband_in;
         turn_deadband_ff       <= turn_deadband_in;
         move_target_ff         <= move_target_in;
         move_heading_ff        <= move_heading_in;
         move_active_ff         <= move_active_in;
         turn_target_ff         <= turn_target_in;
         turn_start_distance_ff <= turn_start_distance_in;
         turn_active_ff         <= turn_active_in;
         reach_target_ff        <= reach_target_in;
         reach_heading_ff       <= reach_heading_in;
         reach_forward_ff       <= reach_forward_in;
         reach_active_ff        <= reach_active_in;
         rsp_valid_ff           <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && req_tick) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: sv/phdc_checker.sv
// ---------------------------------------------------------------------------
// Position hold drive controller checker
// Port-level checks on beat flow through the result register.
// ---------------------------------------------------------------------------
module phdc_checker
   import phdc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [2:0] req_op,
   input logic       rsp_valid,
   input logic       rsp_ready
);

   logic req_fire;
   logic req_tick;

   assign req_fire = req_valid && req_ready;
   assign req_tick = (req_op == OP_POSITION) || (req_op == OP_DISTANCE);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled result beat dropped");

   a_tick_gives_beat: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tick |=> rsp_valid)
      else $error("tick beat gave no result");

   a_command_no_beat: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_tick && (!rsp_valid || rsp_ready) |=> !rsp_valid)
      else $error("command beat gave a result");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

endmodule

bind position_hold_drive_controller phdc_checker u_phdc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_op    (req_chan.payload.op),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);
